### src/ddft_pkg.sv
// shared types, constants and twiddle lookup for the direct dft engine
// no dependencies; used by every module of the block

package ddft_pkg;

  localparam int MAX_LOG2   = 6;
  localparam int MAX_POINTS = 1 << MAX_LOG2;
  localparam int BANKS_LOG2 = 1;
  localparam int MEM_AW     = MAX_LOG2 + BANKS_LOG2;
  localparam int SAMPLE_W   = 16;
  localparam int BIN_W      = 23;
  localparam int ACC_W      = 40;
  localparam int LOG2_W     = 3;
  localparam int RESET_LOG2 = 6;

  // register index of log2_length (byte address 4*index)
  localparam logic REG_LOG2_LENGTH = 1'b0;

  localparam logic signed [SAMPLE_W-1:0] QSINE [17] = '{
    16'sd0,     16'sd3212,  16'sd6393,  16'sd9512,  16'sd12540, 16'sd15447,
    16'sd18205, 16'sd20788, 16'sd23170, 16'sd25330, 16'sd27245, 16'sd28899,
    16'sd30274, 16'sd31357, 16'sd32138, 16'sd32610, 16'sd32767
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } sample_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    sample_t           data;
  } wr_t;

  typedef struct packed {
    logic              bank;
    logic [LOG2_W-1:0] log2;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [LOG2_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_EMIT
  } back_state_t;

  // sine of 2*pi*j/64 in q1.15, symmetric quarter-wave table
  function automatic logic signed [SAMPLE_W-1:0] rom_sin(input logic [MAX_LOG2-1:0] j);
    logic [4:0]                 r_idx;
    logic signed [SAMPLE_W-1:0] v;
    r_idx = j[4] ? (5'd16 - {1'b0, j[3:0]}) : {1'b0, j[3:0]};
    v = QSINE[r_idx];
    rom_sin = j[5] ? -v : v;
  endfunction

  // length mask n-1 for n = 2^l
  function automatic logic [MAX_LOG2-1:0] len_mask(input logic [LOG2_W-1:0] l);
    len_mask = MAX_LOG2'((7'd1 << l) - 7'd1);
  endfunction

endpackage

### src/ddft_front.sv
// front end: takes sample beats, fills the free store bank, posts frame jobs
// depends on ddft_pkg

module ddft_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           in_sample_real,
  input  logic signed [15:0]           in_sample_imag,
  input  ddft_pkg::cfg_wr_t            cfg_wr,
  output logic [ddft_pkg::LOG2_W-1:0]  log2_length,
  input  logic                         frame_done,
  output ddft_pkg::wr_t                mem_wr,
  output logic                         job_push,
  output ddft_pkg::job_t               job
);

  logic [ddft_pkg::LOG2_W-1:0]   log2_r;
  logic [ddft_pkg::MAX_LOG2-1:0] count_r, count_nxt;
  logic                          wbank_r, wbank_nxt;
  logic [1:0]                    outstanding_r, outstanding_nxt;
  logic [ddft_pkg::LOG2_W-1:0]   l_act;
  logic                          accept;
  logic                          last;

  // clamp the length register to 1..6
  always_comb begin
    if (log2_r == 3'd0) begin
      l_act = 3'd1;
    end else if (log2_r > 3'(ddft_pkg::MAX_LOG2)) begin
      l_act = 3'(ddft_pkg::MAX_LOG2);
    end else begin
      l_act = log2_r;
    end
  end

  // two banks: room for a new frame while fewer than two are outstanding
  assign in_ready = (outstanding_r != 2'd2);
  assign accept   = in_valid && in_ready;
  assign last     = (count_r == ddft_pkg::len_mask(l_act));

  assign mem_wr.en        = accept;
  assign mem_wr.addr      = {wbank_r, count_r};
  assign mem_wr.data.re   = in_sample_real;
  assign mem_wr.data.im   = in_sample_imag;
  assign job_push         = accept && last;
  assign job.bank         = wbank_r;
  assign job.log2         = l_act;
  assign log2_length      = log2_r;

  always_comb begin
    count_nxt       = count_r;
    wbank_nxt       = wbank_r;
    outstanding_nxt = outstanding_r;
    if (accept) begin
      count_nxt = last ? '0 : count_r + 1'b1;
      if (last) begin
        wbank_nxt = ~wbank_r;
      end
    end
    if (cfg_wr.en) begin
      count_nxt = '0;
    end
    if (job_push && !frame_done) begin
      outstanding_nxt = outstanding_r + 2'd1;
    end else if (!job_push && frame_done) begin
      outstanding_nxt = outstanding_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r        <= 3'(ddft_pkg::RESET_LOG2);
      count_r       <= '0;
      wbank_r       <= 1'b0;
      outstanding_r <= 2'd0;
    end else begin
      if (cfg_wr.en) begin
        log2_r <= cfg_wr.data;
      end
      count_r       <= count_nxt;
      wbank_r       <= wbank_nxt;
      outstanding_r <= outstanding_nxt;
    end
  end

  // at most two frames own the two banks
  a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r != 2'd3)
    else $error("more than two frames outstanding");

endmodule

### src/ddft_fifo.sv
// two-entry job queue between front and back
// depends on ddft_pkg

module ddft_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ddft_pkg::job_t push_job,
  input  logic           pop,
  output ddft_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  ddft_pkg::job_t slot_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     count_r;

  assign head  = slot_r[rptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job popped from empty queue");

endmodule

### src/ddft_back.sv
// back end: sample store, twiddle lookup, complex mac and result register
// depends on ddft_pkg

module ddft_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ddft_pkg::wr_t          mem_wr,
  input  ddft_pkg::job_t         job,
  input  logic                   job_empty,
  output logic                   job_pop,
  output logic                   frame_done,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [22:0]     out_bin_real,
  output logic signed [22:0]     out_bin_imag,
  output logic [5:0]             out_bin_number,
  output logic                   out_last_bin
);

  ddft_pkg::sample_t mem [2**ddft_pkg::MEM_AW];

  ddft_pkg::back_state_t state_r, state_nxt;

  logic                                bank_r;
  logic [ddft_pkg::LOG2_W-1:0]         l_r;
  logic [ddft_pkg::MAX_LOG2-1:0]       k_r;
  logic [ddft_pkg::MAX_LOG2-1:0]       m_r;
  logic [ddft_pkg::MAX_LOG2-1:0]       j_r;
  logic [ddft_pkg::MAX_LOG2-1:0]       step_r;
  logic [ddft_pkg::MAX_LOG2-1:0]       mask;
  logic [ddft_pkg::LOG2_W-1:0]         scale;
  logic                                m_last;
  logic                                k_last;
  logic                                issue;
  logic                                load_out;

  logic                                v1_r, v2_r;
  ddft_pkg::sample_t                   x_r;
  logic signed [15:0]                  cos_r, sin_r;
  logic signed [31:0]                  p_rc_r, p_is_r, p_ic_r, p_rs_r;
  logic signed [ddft_pkg::ACC_W-1:0]   acc_re_r, acc_im_r;
  logic signed [ddft_pkg::ACC_W-1:0]   rnd_re, rnd_im;

  logic                                out_valid_r;
  logic signed [22:0]                  out_re_r, out_im_r;
  logic [5:0]                          out_k_r;
  logic                                out_last_r;

  assign mask   = ddft_pkg::len_mask(l_r);
  assign scale  = 3'(ddft_pkg::MAX_LOG2) - l_r;
  assign m_last = (m_r == mask);
  assign k_last = (k_r == mask);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddft_pkg::BK_IDLE: begin
        if (!job_empty) begin
          state_nxt = ddft_pkg::BK_RUN;
        end
      end
      ddft_pkg::BK_RUN: begin
        if (m_last) begin
          state_nxt = ddft_pkg::BK_DRAIN;
        end
      end
      ddft_pkg::BK_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ddft_pkg::BK_EMIT;
        end
      end
      ddft_pkg::BK_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = k_last ? ddft_pkg::BK_IDLE : ddft_pkg::BK_RUN;
        end
      end
      default: state_nxt = ddft_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    job_pop  = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ddft_pkg::BK_IDLE:  job_pop  = !job_empty;
      ddft_pkg::BK_RUN:   issue    = 1'b1;
      ddft_pkg::BK_DRAIN: issue    = 1'b0;
      ddft_pkg::BK_EMIT:  load_out = !out_valid_r || out_ready;
      default:            issue    = 1'b0;
    endcase
  end

  assign frame_done = load_out && k_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddft_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample store, registered read
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    x_r <= mem[{bank_r, m_r}];
  end

  // bin and sample sequencing; twiddle phase advances by k*64/n per sample
  always_ff @(posedge clk) begin
    if (job_pop) begin
      bank_r <= job.bank;
      l_r    <= job.log2;
      k_r    <= '0;
      m_r    <= '0;
      j_r    <= '0;
      step_r <= '0;
    end else if (issue) begin
      m_r <= m_r + 1'b1;
      j_r <= j_r + step_r;
    end else if (load_out && !k_last) begin
      k_r    <= k_r + 1'b1;
      m_r    <= '0;
      j_r    <= '0;
      step_r <= ddft_pkg::MAX_LOG2'((k_r + 1'b1) << scale);
    end
  end

  // twiddle, products, accumulate
  always_ff @(posedge clk) begin
    cos_r <= ddft_pkg::rom_sin(j_r + ddft_pkg::MAX_LOG2'(16));
    sin_r <= ddft_pkg::rom_sin(j_r);
    if (v1_r) begin
      p_rc_r <= x_r.re * cos_r;
      p_is_r <= x_r.im * sin_r;
      p_ic_r <= x_r.im * cos_r;
      p_rs_r <= x_r.re * sin_r;
    end
    if (job_pop || load_out) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      acc_re_r <= acc_re_r + ddft_pkg::ACC_W'(p_rc_r) + ddft_pkg::ACC_W'(p_is_r);
      acc_im_r <= acc_im_r + ddft_pkg::ACC_W'(p_ic_r) - ddft_pkg::ACC_W'(p_rs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  // round half up to q.15
  assign rnd_re = (acc_re_r + ddft_pkg::ACC_W'(16384)) >>> 15;
  assign rnd_im = (acc_im_r + ddft_pkg::ACC_W'(16384)) >>> 15;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_re_r   <= rnd_re[22:0];
      out_im_r   <= rnd_im[22:0];
      out_k_r    <= k_r;
      out_last_r <= k_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_real   = out_re_r;
  assign out_bin_imag   = out_im_r;
  assign out_bin_number = out_k_r;
  assign out_last_bin   = out_last_r;

  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddft_pkg::BK_EMIT) |-> (!v1_r && !v2_r))
    else $error("bin emitted with mac pipeline busy");

  a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> (out_valid_r && out_last_r))
    else $error("frame released without final bin");

endmodule

### src/direct_dft_engine.sv
// direct dft: once an n-point frame is stored its bins are computed in order;
// each bin waits in the emit state until the previous result beat is taken
// one shared complex mac (one sample per cycle plus a 3-stage drain) handles all bins
// samples are taken one per cycle into a free bank unless both banks are in use;
// with two banks a new frame is filled while the mac works on the previous one
// synchronous active-low reset: clears front counters, queue and result valid, length
// to 64; the store is not cleared (entries are always written before they are read)

module direct_dft_engine (
  input  logic               clk,
  input  logic               rst_n,
  // sample beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_real,
  input  logic signed [15:0] in_sample_imag,
  // bin beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [22:0] out_bin_real,
  output logic signed [22:0] out_bin_imag,
  output logic [5:0]         out_bin_number,
  output logic               out_last_bin,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  ddft_pkg::cfg_wr_t                cfg_wr;
  logic [ddft_pkg::LOG2_W-1:0]      log2_length;
  ddft_pkg::wr_t                    mem_wr;
  logic                             job_push;
  ddft_pkg::job_t                   push_job;
  logic                             job_pop;
  ddft_pkg::job_t                   head_job;
  logic                             job_empty;
  logic                             job_full;
  logic                             frame_done;
  logic                             reg_hit;

  // register decode: word index is paddr[2], only log2_length exists
  assign pready      = 1'b1;
  assign reg_hit     = (paddr[2] == ddft_pkg::REG_LOG2_LENGTH);
  assign cfg_wr.en   = psel && penable && pwrite && reg_hit;
  assign cfg_wr.data = pwdata[ddft_pkg::LOG2_W-1:0];
  assign prdata      = reg_hit ? {29'd0, log2_length} : 32'd0;

  // front fills one bank while the back works on the other
  ddft_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_real (in_sample_real),
    .in_sample_imag (in_sample_imag),
    .cfg_wr         (cfg_wr),
    .log2_length    (log2_length),
    .frame_done     (frame_done),
    .mem_wr         (mem_wr),
    .job_push       (job_push),
    .job            (push_job)
  );

  // completed frames wait here for the mac
  ddft_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head     (head_job),
    .empty    (job_empty),
    .full     (job_full)
  );

  // store, twiddles, mac and output register
  ddft_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mem_wr         (mem_wr),
    .job            (head_job),
    .job_empty      (job_empty),
    .job_pop        (job_pop),
    .frame_done     (frame_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bin_real   (out_bin_real),
    .out_bin_imag   (out_bin_imag),
    .out_bin_number (out_bin_number),
    .out_last_bin   (out_last_bin)
  );

  // front never admits a frame the queue cannot hold
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !job_full)
    else $error("sample beat taken with job queue full");

endmodule
